// ===== design/qau_pkg.sv =====
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies.
package qau_pkg;

  localparam int FRAC_BITS = 12;
  localparam int DATA_W    = 16;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_MUL  = 3'd1;
  localparam logic [2:0] OP_CONJ = 3'd2;
  localparam logic [2:0] OP_INV  = 3'd3;
  localparam logic [2:0] OP_NORM = 3'd4;
  localparam logic [2:0] OP_MAT  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [1:0] ROW_LAST = 2'd2;

  localparam int SAT_POS   = (1 << (DATA_W - 1)) - 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NUM_W     = 2 * DATA_W + 2;
  localparam int DIR_W     = NUM_W;
  localparam int MAG_W     = 2 * DATA_W + 1;
  localparam int SQ_W      = 2 * DATA_W + 1;
  localparam int ISQ_W     = 64;
  localparam int ISQ_STEPS = ISQ_W / 2;
  localparam int DEN_W     = SQ_W;
  localparam int D_W       = DEN_W + 1;
  localparam int QB_W      = DATA_W + 1;
  localparam int SHF_W     = MAG_W + FRAC_BITS;
  localparam int N_W       = SHF_W + 2;
  localparam int CMP_W     = ((N_W > D_W + QB_W) ? N_W : D_W + QB_W) + 1;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] a_w;
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] b_w;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_w;
    logic signed [DATA_W-1:0] res_x;
    logic signed [DATA_W-1:0] res_y;
    logic signed [DATA_W-1:0] res_z;
    logic [1:0]               status;
    logic                     last;
  } resp_t;

endpackage

// ===== design/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit: add, product, conjugate, inverse, normalize, rotation matrix.
// Depends on qau_pkg.
//
// Fully pipelined: one request enters per cycle unless the pipeline is held or a
// matrix request is being expanded. A rotation-matrix request occupies three entry
// slots (one per row), so in_ready stays low until its last row enters. The
// pipeline includes the 32-stage square-root chain and the 17-stage quotient chain.
// The whole pipeline holds when a result waits on out_ready.
module quaternion_arithmetic_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qau_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output qau_pkg::resp_t out_data
);
  import qau_pkg::*;

  typedef struct packed {
    logic [2:0]                cmd;
    logic                      last;
    logic                      zero;
    logic [3:0]                neg;
    logic [3:0][MAG_W-1:0]     mag;
    logic [3:0][DIR_W-1:0]     dir;
    logic [SQ_W-1:0]           sq;
  } carry_t;

  logic adv;
  assign adv = !out_valid || out_ready;

  // entry / row sequencer
  logic       s0_valid;
  req_t       s0_req;
  logic [1:0] s0_row;
  logic       s0_busy;

  assign s0_busy  = s0_valid && (s0_req.cmd == OP_MAT) && (s0_row != ROW_LAST);
  assign in_ready = adv && !s0_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s0_row   <= 2'd0;
    end else if (adv) begin
      if (s0_busy) begin
        s0_row <= s0_row + 2'd1;
      end else begin
        s0_valid <= in_valid && (in_data.cmd <= OP_MAT);
        s0_row   <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !s0_busy) begin
      s0_req <= in_data;
    end
  end

  // stage 1: products
  logic signed [DATA_W-1:0] av [4];
  logic signed [DATA_W-1:0] bv [4];
  assign av[0] = s0_req.a_w;
  assign av[1] = s0_req.a_x;
  assign av[2] = s0_req.a_y;
  assign av[3] = s0_req.a_z;
  assign bv[0] = s0_req.b_w;
  assign bv[1] = s0_req.b_x;
  assign bv[2] = s0_req.b_y;
  assign bv[3] = s0_req.b_z;

  logic                     s1_valid;
  logic [2:0]               s1_cmd;
  logic [1:0]               s1_row;
  logic                     s1_last;
  logic signed [DATA_W-1:0] s1_a   [4];
  logic signed [PROD_W-1:0] s1_pm  [16];
  logic signed [PROD_W-1:0] s1_sqr [4];
  logic signed [PROD_W-1:0] s1_cr  [6];
  logic signed [DATA_W:0]   s1_dir [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd  <= s0_req.cmd;
      s1_row  <= s0_row;
      s1_last <= (s0_req.cmd != OP_MAT) || (s0_row == ROW_LAST);
      for (int i = 0; i < 4; i++) begin
        s1_a[i]   <= av[i];
        s1_sqr[i] <= av[i] * av[i];
        for (int j = 0; j < 4; j++) begin
          s1_pm[i*4+j] <= av[i] * bv[j];
        end
        if (s0_req.cmd == OP_CONJ && i != 0) begin
          s1_dir[i] <= -(DATA_W+1)'(av[i]);
        end else if (s0_req.cmd == OP_CONJ) begin
          s1_dir[i] <= (DATA_W+1)'(av[i]);
        end else begin
          s1_dir[i] <= (DATA_W+1)'(av[i]) + (DATA_W+1)'(bv[i]);
        end
      end
      s1_cr[0] <= av[1] * av[2];
      s1_cr[1] <= av[3] * av[0];
      s1_cr[2] <= av[1] * av[3];
      s1_cr[3] <= av[2] * av[0];
      s1_cr[4] <= av[2] * av[3];
      s1_cr[5] <= av[1] * av[0];
    end
  end

  // stage 2: sums, matrix entries, numerators
  logic signed [NUM_W-1:0] e_sq [4];
  logic signed [NUM_W-1:0] e_cr [6];
  logic signed [NUM_W-1:0] e_pm [16];
  logic signed [NUM_W-1:0] mm   [3][3];
  logic signed [NUM_W-1:0] mul_c [4];
  logic signed [NUM_W-1:0] num_c [4];
  logic signed [NUM_W-1:0] dir_c [4];
  logic [SQ_W-1:0]         sq_c;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e_sq[i] = NUM_W'(s1_sqr[i]);
    end
    for (int i = 0; i < 6; i++) begin
      e_cr[i] = NUM_W'(s1_cr[i]);
    end
    for (int i = 0; i < 16; i++) begin
      e_pm[i] = NUM_W'(s1_pm[i]);
    end
    sq_c = SQ_W'(e_sq[0] + e_sq[1] + e_sq[2] + e_sq[3]);

    mm[0][0] = e_sq[1] - e_sq[2] - e_sq[3] + e_sq[0];
    mm[1][1] = e_sq[2] - e_sq[1] - e_sq[3] + e_sq[0];
    mm[2][2] = e_sq[3] - e_sq[1] - e_sq[2] + e_sq[0];
    mm[1][0] = (e_cr[0] + e_cr[1]) <<< 1;
    mm[0][1] = (e_cr[0] - e_cr[1]) <<< 1;
    mm[2][0] = (e_cr[2] - e_cr[3]) <<< 1;
    mm[0][2] = (e_cr[2] + e_cr[3]) <<< 1;
    mm[2][1] = (e_cr[4] + e_cr[5]) <<< 1;
    mm[1][2] = (e_cr[4] - e_cr[5]) <<< 1;

    // Hamilton product, p(i,j) = a_i * b_j
    mul_c[0] = e_pm[0] - e_pm[5] - e_pm[10] - e_pm[15];
    mul_c[1] = e_pm[11] - e_pm[14] + e_pm[1] + e_pm[4];
    mul_c[2] = e_pm[13] - e_pm[7] + e_pm[2] + e_pm[8];
    mul_c[3] = e_pm[6] - e_pm[9] + e_pm[3] + e_pm[12];

    for (int i = 0; i < 4; i++) begin
      dir_c[i] = (s1_cmd == OP_MUL) ? mul_c[i] : NUM_W'(s1_dir[i]);
      case (s1_cmd)
        OP_INV: begin
          num_c[i] = (i == 0) ? NUM_W'(s1_a[i]) : -NUM_W'(s1_a[i]);
        end
        OP_NORM: begin
          num_c[i] = NUM_W'(s1_a[i]);
        end
        OP_MAT: begin
          num_c[i] = (i == 0) ? '0 : mm[s1_row][i-1];
        end
        default: begin
          num_c[i] = '0;
        end
      endcase
    end
  end

  logic                    s2_valid;
  logic [2:0]              s2_cmd;
  logic                    s2_last;
  logic [SQ_W-1:0]         s2_sq;
  logic signed [NUM_W-1:0] s2_num [4];
  logic signed [DIR_W-1:0] s2_dir [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd  <= s1_cmd;
      s2_last <= s1_last;
      s2_sq   <= sq_c;
      for (int i = 0; i < 4; i++) begin
        s2_num[i] <= num_c[i];
        s2_dir[i] <= dir_c[i];
      end
    end
  end

  // square root chain, one result bit per stage
  logic                 ch_valid [ISQ_STEPS+1];
  carry_t               ch       [ISQ_STEPS+1];
  logic [ISQ_W-1:0]     isq_n    [ISQ_STEPS+1];
  logic [ISQ_W-1:0]     isq_r    [ISQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid[0] <= 1'b0;
    end else if (adv) begin
      ch_valid[0] <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch[0].cmd  <= s2_cmd;
      ch[0].last <= s2_last;
      ch[0].zero <= (s2_sq == '0);
      ch[0].sq   <= s2_sq;
      for (int i = 0; i < 4; i++) begin
        ch[0].neg[i] <= s2_num[i][NUM_W-1];
        ch[0].mag[i] <= s2_num[i][NUM_W-1] ? MAG_W'(-s2_num[i]) : MAG_W'(s2_num[i]);
        ch[0].dir[i] <= s2_dir[i];
      end
      isq_n[0] <= ISQ_W'(s2_sq) << (2 * FRAC_BITS);
      isq_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_isq
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (ISQ_W - 2 - 2 * g);
    logic [ISQ_W-1:0] t;
    logic             ge;
    assign t  = isq_r[g] + BIT;
    assign ge = isq_n[g] >= t;

    always_ff @(posedge clk) begin
      if (rst) begin
        ch_valid[g+1] <= 1'b0;
      end else if (adv) begin
        ch_valid[g+1] <= ch_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ch[g+1]    <= ch[g];
        isq_n[g+1] <= ge ? isq_n[g] - t : isq_n[g];
        isq_r[g+1] <= ge ? (isq_r[g] >> 1) + BIT : isq_r[g] >> 1;
      end
    end
  end

  // divider setup: round(num / den) as floor((2*num + den) / (2*den))
  logic [DEN_W-1:0]       den_c;
  logic [D_W-1:0]         dd_c;
  logic [3:0][N_W-1:0]    nn_c;
  logic [3:0]             ovf_c;
  logic [SHF_W-1:0]       shm [4];

  always_comb begin
    den_c = (ch[ISQ_STEPS].cmd == OP_NORM) ? DEN_W'(isq_r[ISQ_STEPS]) : ch[ISQ_STEPS].sq;
    dd_c  = {den_c, 1'b0};
    for (int i = 0; i < 4; i++) begin
      shm[i] = (ch[ISQ_STEPS].cmd == OP_MAT) ?
               (SHF_W'(ch[ISQ_STEPS].mag[i]) << FRAC_BITS) :
               (SHF_W'(ch[ISQ_STEPS].mag[i]) << (2 * FRAC_BITS));
      nn_c[i]  = N_W'({shm[i], 1'b0}) + N_W'(den_c);
      ovf_c[i] = CMP_W'(nn_c[i]) >= (CMP_W'(dd_c) << QB_W);
    end
  end

  logic                   dv_valid [QB_W+1];
  carry_t                 dv_c     [QB_W+1];
  logic [D_W-1:0]         dv_d     [QB_W+1];
  logic [3:0][N_W-1:0]    dv_rem   [QB_W+1];
  logic [3:0][QB_W-1:0]   dv_q     [QB_W+1];
  logic [3:0]             dv_ovf   [QB_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= ch_valid[ISQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_c[0]   <= ch[ISQ_STEPS];
      dv_d[0]   <= dd_c;
      dv_rem[0] <= nn_c;
      dv_q[0]   <= '0;
      dv_ovf[0] <= ovf_c;
    end
  end

  // restoring division, one quotient bit per stage, four lanes
  for (genvar g = 0; g < QB_W; g++) begin : g_div
    localparam int K = QB_W - 1 - g;
    logic [CMP_W-1:0]    sub;
    logic [3:0][N_W-1:0] rem_n;
    logic [3:0][QB_W-1:0] q_n;
    assign sub = CMP_W'(dv_d[g]) << K;

    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic ge;
      assign ge = CMP_W'(dv_rem[g][l]) >= sub;
      assign rem_n[l] = ge ? N_W'(CMP_W'(dv_rem[g][l]) - sub) : dv_rem[g][l];
      assign q_n[l]   = dv_q[g][l] | (ge ? (QB_W'(1) << K) : '0);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[g+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[g+1] <= dv_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_c[g+1]   <= dv_c[g];
        dv_d[g+1]   <= dv_d[g];
        dv_rem[g+1] <= rem_n;
        dv_q[g+1]   <= q_n;
        dv_ovf[g+1] <= dv_ovf[g];
      end
    end
  end

  // final rounding, saturation and status
  carry_t                   fc;
  logic signed [DATA_W-1:0] fv  [4];
  logic [3:0]               fsat;
  logic                     divop;
  resp_t                    fin;

  always_comb begin
    logic [QB_W-1:0]      q;
    logic signed [DIR_W:0] v;
    fc    = dv_c[QB_W];
    divop = (fc.cmd == OP_INV) || (fc.cmd == OP_NORM) || (fc.cmd == OP_MAT);
    for (int l = 0; l < 4; l++) begin
      q = dv_q[QB_W][l];
      v = (DIR_W+1)'(signed'(fc.dir[l]));
      if (fc.cmd == OP_MUL) begin
        v = (v + (DIR_W+1)'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      end
      fsat[l] = 1'b0;
      if (divop) begin
        if (fc.neg[l]) begin
          if (dv_ovf[QB_W][l] || q > QB_W'(SAT_POS + 1)) begin
            fv[l]   = DATA_W'(-(SAT_POS + 1));
            fsat[l] = 1'b1;
          end else begin
            fv[l] = DATA_W'(-signed'({1'b0, q}));
          end
        end else begin
          if (dv_ovf[QB_W][l] || q > QB_W'(SAT_POS)) begin
            fv[l]   = DATA_W'(SAT_POS);
            fsat[l] = 1'b1;
          end else begin
            fv[l] = DATA_W'(q);
          end
        end
      end else begin
        if (v > (DIR_W+1)'(SAT_POS)) begin
          fv[l]   = DATA_W'(SAT_POS);
          fsat[l] = 1'b1;
        end else if (v < (DIR_W+1)'(-(SAT_POS + 1))) begin
          fv[l]   = DATA_W'(-(SAT_POS + 1));
          fsat[l] = 1'b1;
        end else begin
          fv[l] = DATA_W'(v);
        end
      end
    end

    fin.last = fc.last;
    if (divop && fc.zero) begin
      fin.res_w  = '0;
      fin.res_x  = '0;
      fin.res_y  = '0;
      fin.res_z  = '0;
      fin.status = ST_ZERO;
    end else begin
      fin.res_w  = fv[0];
      fin.res_x  = fv[1];
      fin.res_y  = fv[2];
      fin.res_z  = fv[3];
      fin.status = (fsat != '0) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[QB_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= fin;
    end
  end

endmodule
